[rtl/core/vspp_pkg.sv]
// vspp_pkg: shared types and constants for the voxel sphere paint and probe block
// holds the transaction payload structs, operation codes and register map
// no dependencies
`default_nettype none

package vspp_pkg;

   // fixed-point format of coordinates, step and radius
   localparam int COORD_FRAC_BITS = 16;

   localparam int POS_W    = 32;
   localparam int RADIUS_W = 24;
   localparam int STEP_W   = 24;
   localparam int CELLS_W  = 7;
   localparam int OP_W     = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_PAINT  = 2'd0;
   localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INVERT = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_X   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_Y   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CELLS_Z   = 3'd6;

   // reset values
   localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd32768;
   localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd64;

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic signed [POS_W-1:0]    pos_z;
      logic [RADIUS_W-1:0]        radius;
   } req_type;

   typedef struct packed {
      logic [OP_W-1:0] done_operation;
      logic            flag;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/voxel_sphere_paint_and_probe_top.sv]
// voxel_sphere_paint_and_probe_top: 3d occupancy bitmap with sphere paint, point probe,
// invert and clear, run by one sequencer around a shared multiplier and divider
// depends on vspp_pkg
`default_nettype none

// Usage: one transaction at a time. After reset the bitmap is swept to zero, one cell
// a cycle, over all MAX_CELLS_X*MAX_CELLS_Y*MAX_CELLS_Z cells, and req_ready stays low
// until that pass ends (register writes are taken throughout). Each floor division by
// the step runs on a restoring divider, one quotient bit a cycle. A paint does six
// divisions and its setup (radius squared, plane and row strides, the start distance
// of each axis), then walks the clamped index box, each axis from its low bound up to
// but not including its high bound: a z plane or y row whose axis distance is beyond
// the radius is skipped, the others go on to the inner walk, and an x cell beyond the
// radius is skipped while the others reach the distance test. A probe does three
// divisions, the two address multiplies and one memory read, and skips the read when
// the point lies outside the grid. Invert reads and rewrites each cell in use. Clear
// sweeps the whole store, one cell a cycle. The result register frees the sequencer as
// soon as its transaction is stored, so a new request is taken while the previous
// response still waits on rsp_ready.
module voxel_sphere_paint_and_probe_top #(
   parameter int MAX_CELLS_X = 64,
   parameter int MAX_CELLS_Y = 64,
   parameter int MAX_CELLS_Z = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  vspp_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output vspp_pkg::rsp_type                rsp_payload,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [vspp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [vspp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vspp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   // sizes
   localparam int TOTAL = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;
   localparam int AW    = $clog2(TOTAL);
   localparam int MAXM0 = (MAX_CELLS_X > MAX_CELLS_Y) ? MAX_CELLS_X : MAX_CELLS_Y;
   localparam int MAXM  = (MAXM0 > MAX_CELLS_Z) ? MAXM0 : MAX_CELLS_Z;
   localparam int CW0   = $clog2(MAXM + 1);
   localparam int CW    = (CW0 > vspp_pkg::CELLS_W) ? CW0 : vspp_pkg::CELLS_W;
   localparam int RW    = vspp_pkg::RADIUS_W;
   localparam int SW    = vspp_pkg::STEP_W;
   localparam int MA    = (AW > RW) ? AW : RW;
   localparam int PW    = MA + RW;
   localparam int NW    = 34;   // dividend: position - origin +/- reach
   localparam int QW    = NW + 1;
   localparam int DCW   = $clog2(NW);
   localparam int LW    = CW + SW;   // index times step
   localparam int DW    = ((LW > 32) ? LW : 32) + 2;
   localparam int SQW   = 2 * RW;
   localparam int REACH_ONE = 1 << vspp_pkg::COORD_FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_CLR, ST_D_LOAD, ST_D_RUN, ST_D_END,
      ST_PR_R2, ST_PR_CXY, ST_PR_PLANE, ST_PR_YOFS, ST_PR_M, ST_PR_A,
      ST_PZ_CHK, ST_PZ_SQ, ST_PY_CHK, ST_PY_SQ, ST_PY_SUM,
      ST_PX_CHK, ST_PX_SQ, ST_PX_TEST,
      ST_PB_M1, ST_PB_A1, ST_PB_M2, ST_PB_A2, ST_PB_RD, ST_PB_FIN,
      ST_INV_CXY, ST_INV_N, ST_INV_RD, ST_INV_WR, ST_DONE
   } state_type;

   // configuration registers
   logic signed [31:0]               origin_x_ff, origin_y_ff, origin_z_ff;
   logic [SW-1:0]                    step_size_ff;
   logic [vspp_pkg::CELLS_W-1:0]     cells_x_ff, cells_y_ff, cells_z_ff;
   logic [vspp_pkg::REG_IDX_W-1:0]   csr_idx;
   logic                             csr_wr;

   // sequencer state and working registers
   state_type                        state_ff;
   logic [vspp_pkg::OP_W-1:0]        op_ff;
   logic signed [31:0]               p_ff [3];
   logic [RW-1:0]                    r_ff;
   logic [SW-1:0]                    st_ff;
   logic [CW-1:0]                    cnt_ff [3];
   logic [CW-1:0]                    lo_ff [3];
   logic [CW-1:0]                    hi_ff [3];
   logic [1:0]                       axis_ff;
   logic                             side_ff;
   logic                             bad_ff;
   logic                             neg_ff;
   logic [NW-1:0]                    dnum_ff;
   logic [SW-1:0]                    rem_ff;
   logic [DCW-1:0]                   dcnt_ff;
   logic [SQW-1:0]                   r2_ff;
   logic [AW-1:0]                    cxy_ff;
   logic [AW-1:0]                    plane_ff;
   logic [AW-1:0]                    yofs_ff;
   logic [AW-1:0]                    row_ff;
   logic [AW-1:0]                    t_ff;
   logic [AW-1:0]                    addr_ff;
   logic [AW:0]                      n_ff;
   logic [AW:0]                      sweep_ff;
   logic [LW-1:0]                    prod_ff;
   logic signed [DW-1:0]             dstart_ff [2];
   logic signed [DW-1:0]             dist_x_ff, dist_y_ff, dist_z_ff;
   logic [DW-1:0]                    mag_ff;
   logic [SQW-1:0]                   sq_ff;
   logic [SQW-1:0]                   dz2_ff;
   logic [SQW:0]                     dyz_ff;
   logic [CW-1:0]                    x_ff, y_ff, z_ff;
   logic                             any_ff;
   logic                             flag_ff;
   logic                             rsp_valid_ff;
   vspp_pkg::rsp_type                rsp_ff;

   // occupancy store
   logic                             occ_ff [TOTAL];
   logic                             occ_rd_ff;
   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic                             mem_wdata;
   logic [AW-1:0]                    mem_raddr;

   // combinational helpers
   logic [CW-1:0]                    cx_eff, cy_eff, cz_eff;
   logic [SW-1:0]                    st_eff;
   logic signed [31:0]               org_sel, p_sel;
   logic [CW-1:0]                    lo_sel, cnt_sel;
   logic signed [NW-1:0]             num_base, num_reach, num;
   logic [NW-1:0]                    num_abs;
   logic [SW:0]                      rem_sh, rem_sub;
   logic                             div_ge;
   logic [QW-1:0]                    qmag, qs, cnt_q;
   logic                             q_neg, q_ge_cnt, q_gt_last, q_bad;
   logic [CW-1:0]                    q_clamp;
   logic signed [DW-1:0]             dist_new, mag_src;
   logic [DW-1:0]                    mag_val;
   logic                             mag_out;
   logic [SQW+1:0]                   hit_sum;
   logic                             hit;
   logic [AW-1:0]                    cell_addr;
   logic [MA-1:0]                    mul_a;
   logic [RW-1:0]                    mul_b;
   logic [PW-1:0]                    mul_p;

   // ---------------------------------------------------------------------
   // configuration port: always ready, write on the access phase
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         step_size_ff <= vspp_pkg::STEP_RESET;
         cells_x_ff   <= vspp_pkg::CELLS_RESET;
         cells_y_ff   <= vspp_pkg::CELLS_RESET;
         cells_z_ff   <= vspp_pkg::CELLS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            vspp_pkg::REG_ORIGIN_X:  origin_x_ff  <= csr_pwdata;
            vspp_pkg::REG_ORIGIN_Y:  origin_y_ff  <= csr_pwdata;
            vspp_pkg::REG_ORIGIN_Z:  origin_z_ff  <= csr_pwdata;
            vspp_pkg::REG_STEP_SIZE: step_size_ff <= csr_pwdata[SW-1:0];
            vspp_pkg::REG_CELLS_X:   cells_x_ff   <= csr_pwdata[vspp_pkg::CELLS_W-1:0];
            vspp_pkg::REG_CELLS_Y:   cells_y_ff   <= csr_pwdata[vspp_pkg::CELLS_W-1:0];
            vspp_pkg::REG_CELLS_Z:   cells_z_ff   <= csr_pwdata[vspp_pkg::CELLS_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         vspp_pkg::REG_ORIGIN_X:  csr_prdata = origin_x_ff;
         vspp_pkg::REG_ORIGIN_Y:  csr_prdata = origin_y_ff;
         vspp_pkg::REG_ORIGIN_Z:  csr_prdata = origin_z_ff;
         vspp_pkg::REG_STEP_SIZE: csr_prdata = 32'(step_size_ff);
         vspp_pkg::REG_CELLS_X:   csr_prdata = 32'(cells_x_ff);
         vspp_pkg::REG_CELLS_Y:   csr_prdata = 32'(cells_y_ff);
         vspp_pkg::REG_CELLS_Z:   csr_prdata = 32'(cells_z_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // effective counts saturate at the build maximum, zero step acts as one
   assign cx_eff = (CW'(cells_x_ff) > CW'(MAX_CELLS_X)) ? CW'(MAX_CELLS_X) : CW'(cells_x_ff);
   assign cy_eff = (CW'(cells_y_ff) > CW'(MAX_CELLS_Y)) ? CW'(MAX_CELLS_Y) : CW'(cells_y_ff);
   assign cz_eff = (CW'(cells_z_ff) > CW'(MAX_CELLS_Z)) ? CW'(MAX_CELLS_Z) : CW'(cells_z_ff);
   assign st_eff = (step_size_ff == '0) ? SW'(1) : step_size_ff;

   // ---------------------------------------------------------------------
   // per-axis selection
   // ---------------------------------------------------------------------
   always_comb begin
      org_sel = origin_x_ff;
      unique case (axis_ff)
         2'd0:    org_sel = origin_x_ff;
         2'd1:    org_sel = origin_y_ff;
         default: org_sel = origin_z_ff;
      endcase
   end

   assign p_sel   = p_ff[axis_ff];
   assign lo_sel  = lo_ff[axis_ff];
   assign cnt_sel = cnt_ff[axis_ff];

   // dividend: position - origin, widened by reach = radius + 1 for paint bounds
   assign num_base  = {{(NW-32){p_sel[31]}}, p_sel} - {{(NW-32){org_sel[31]}}, org_sel};
   assign num_reach = NW'(r_ff) + NW'(REACH_ONE);
   always_comb begin
      num = num_base;
      if (op_ff == vspp_pkg::OP_PAINT) begin
         num = side_ff ? (num_base + num_reach) : (num_base - num_reach);
      end
   end
   assign num_abs = num[NW-1] ? (~num + NW'(1)) : num;

   // restoring divider step, one quotient bit a cycle
   assign rem_sh  = {rem_ff, dnum_ff[NW-1]};
   assign div_ge  = (rem_sh >= {1'b0, st_ff});
   assign rem_sub = rem_sh - {1'b0, st_ff};

   // floor fix-up: negative dividend rounds toward minus infinity
   assign qmag      = {1'b0, dnum_ff};
   assign qs        = !neg_ff ? qmag : ((rem_ff != '0) ? ~qmag : (~qmag + QW'(1)));
   assign q_neg     = qs[QW-1];
   assign cnt_q     = QW'(cnt_sel);
   assign q_ge_cnt  = !q_neg && (qs >= cnt_q);
   assign q_gt_last = !q_neg && (qs > (cnt_q - QW'(1)));
   assign q_bad     = q_neg || q_ge_cnt;
   assign q_clamp   = q_neg ? '0 : (q_gt_last ? (cnt_sel - CW'(1)) : qs[CW-1:0]);

   // lattice distance of the first index: origin + lo*step - center
   assign dist_new = {{(DW-32){org_sel[31]}}, org_sel} + DW'(prod_ff)
                   - {{(DW-32){p_sel[31]}}, p_sel};

   always_comb begin
      mag_src = dist_x_ff;
      case (state_ff)
         ST_PZ_CHK: mag_src = dist_z_ff;
         ST_PY_CHK: mag_src = dist_y_ff;
         default:   mag_src = dist_x_ff;
      endcase
   end
   assign mag_val = mag_src[DW-1] ? DW'(~mag_src + DW'(1)) : DW'(mag_src);
   assign mag_out = (mag_ff > DW'(r_ff));

   assign hit_sum   = (SQW+2)'(sq_ff) + (SQW+2)'(dyz_ff);
   assign hit       = (hit_sum <= (SQW+2)'(r2_ff));
   assign cell_addr = row_ff + AW'(x_ff);

   // ---------------------------------------------------------------------
   // shared multiplier, operands picked by the sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff) inside
         ST_PR_R2: begin
            mul_a = MA'(r_ff);
            mul_b = r_ff;
         end
         ST_PR_CXY, ST_INV_CXY: begin
            mul_a = MA'(cnt_ff[0]);
            mul_b = RW'(cnt_ff[1]);
         end
         ST_PR_PLANE: begin
            mul_a = MA'(cxy_ff);
            mul_b = RW'(lo_ff[2]);
         end
         ST_PR_YOFS: begin
            mul_a = MA'(cnt_ff[0]);
            mul_b = RW'(lo_ff[1]);
         end
         ST_PR_M: begin
            mul_a = MA'(lo_sel);
            mul_b = RW'(st_ff);
         end
         ST_PZ_SQ, ST_PY_SQ, ST_PX_SQ: begin
            mul_a = MA'(mag_ff[RW-1:0]);
            mul_b = mag_ff[RW-1:0];
         end
         ST_PB_M1: begin
            mul_a = MA'(cnt_ff[1]);
            mul_b = RW'(lo_ff[2]);
         end
         ST_PB_M2: begin
            mul_a = MA'(t_ff);
            mul_b = RW'(cnt_ff[0]);
         end
         ST_INV_N: begin
            mul_a = MA'(cxy_ff);
            mul_b = RW'(cnt_ff[2]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // ---------------------------------------------------------------------
   // occupancy store: one write and one registered read a cycle
   // ---------------------------------------------------------------------
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff[AW-1:0];
      mem_wdata = 1'b0;
      mem_raddr = sweep_ff[AW-1:0];
      unique case (state_ff) inside
         ST_INIT, ST_CLR: mem_we = 1'b1;
         ST_INV_WR: begin
            mem_we    = 1'b1;
            mem_wdata = ~occ_rd_ff;
         end
         ST_PX_TEST: begin
            mem_we    = hit;
            mem_waddr = cell_addr;
            mem_wdata = 1'b1;
         end
         ST_PB_RD: mem_raddr = addr_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_ff[mem_waddr] <= mem_wdata;
      end
      occ_rd_ff <= occ_ff[mem_raddr];
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         side_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         any_ff       <= 1'b0;
      end else begin
         // a taken response empties the output register unless a new one loads
         if (rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // clearing pass after reset
            ST_INIT: begin
               sweep_ff <= sweep_ff + (AW+1)'(1);
               if (sweep_ff == (AW+1)'(TOTAL - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_payload.operation;
                  p_ff[0]   <= req_payload.pos_x;
                  p_ff[1]   <= req_payload.pos_y;
                  p_ff[2]   <= req_payload.pos_z;
                  r_ff      <= req_payload.radius;
                  st_ff     <= st_eff;
                  cnt_ff[0] <= cx_eff;
                  cnt_ff[1] <= cy_eff;
                  cnt_ff[2] <= cz_eff;
                  axis_ff   <= '0;
                  side_ff   <= 1'b0;
                  bad_ff    <= 1'b0;
                  any_ff    <= 1'b0;
                  flag_ff   <= 1'b0;
                  sweep_ff  <= '0;
                  if (req_payload.operation == vspp_pkg::OP_CLEAR) begin
                     state_ff <= ST_CLR;
                  end else if (cx_eff == '0 || cy_eff == '0 || cz_eff == '0) begin
                     // empty grid: nothing to touch, flag stays low
                     state_ff <= ST_DONE;
                  end else if (req_payload.operation == vspp_pkg::OP_INVERT) begin
                     state_ff <= ST_INV_CXY;
                  end else begin
                     state_ff <= ST_D_LOAD;
                  end
               end
            end

            ST_CLR: begin
               sweep_ff <= sweep_ff + (AW+1)'(1);
               if (sweep_ff == (AW+1)'(TOTAL - 1)) begin
                  state_ff <= ST_DONE;
               end
            end

            // floor division by the step, one axis bound at a time
            ST_D_LOAD: begin
               neg_ff   <= num[NW-1];
               dnum_ff  <= num_abs;
               rem_ff   <= '0;
               dcnt_ff  <= DCW'(NW - 1);
               state_ff <= ST_D_RUN;
            end

            ST_D_RUN: begin
               rem_ff  <= div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
               dnum_ff <= {dnum_ff[NW-2:0], div_ge};
               dcnt_ff <= dcnt_ff - DCW'(1);
               if (dcnt_ff == '0) begin
                  state_ff <= ST_D_END;
               end
            end

            ST_D_END: begin
               if (op_ff == vspp_pkg::OP_PAINT) begin
                  if (!side_ff) begin
                     lo_ff[axis_ff] <= q_clamp;
                     side_ff        <= 1'b1;
                     state_ff       <= ST_D_LOAD;
                  end else begin
                     hi_ff[axis_ff] <= q_clamp;
                     side_ff        <= 1'b0;
                     if (axis_ff == 2'd2) begin
                        state_ff <= ST_PR_R2;
                     end else begin
                        axis_ff  <= axis_ff + 2'd1;
                        state_ff <= ST_D_LOAD;
                     end
                  end
               end else begin
                  // probe: the cell index itself, no clamping
                  lo_ff[axis_ff] <= qs[CW-1:0];
                  bad_ff         <= bad_ff | q_bad;
                  if (axis_ff == 2'd2) begin
                     state_ff <= (bad_ff || q_bad) ? ST_DONE : ST_PB_M1;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_D_LOAD;
                  end
               end
            end

            // paint setup
            ST_PR_R2: begin
               r2_ff    <= mul_p[SQW-1:0];
               state_ff <= ST_PR_CXY;
            end

            ST_PR_CXY: begin
               cxy_ff   <= mul_p[AW-1:0];
               state_ff <= ST_PR_PLANE;
            end

            ST_PR_PLANE: begin
               plane_ff <= mul_p[AW-1:0];
               state_ff <= ST_PR_YOFS;
            end

            ST_PR_YOFS: begin
               yofs_ff  <= mul_p[AW-1:0];
               axis_ff  <= '0;
               state_ff <= ST_PR_M;
            end

            ST_PR_M: begin
               prod_ff  <= mul_p[LW-1:0];
               state_ff <= ST_PR_A;
            end

            ST_PR_A: begin
               if (axis_ff == 2'd2) begin
                  dist_z_ff <= dist_new;
                  z_ff      <= lo_ff[2];
                  state_ff  <= ST_PZ_CHK;
               end else begin
                  dstart_ff[axis_ff[0]] <= dist_new;
                  axis_ff               <= axis_ff + 2'd1;
                  state_ff              <= ST_PR_M;
               end
            end

            // z planes
            ST_PZ_CHK: begin
               if (z_ff >= hi_ff[2]) begin
                  flag_ff  <= any_ff;
                  state_ff <= ST_DONE;
               end else begin
                  mag_ff   <= mag_val;
                  state_ff <= ST_PZ_SQ;
               end
            end

            ST_PZ_SQ: begin
               if (mag_out) begin
                  z_ff      <= z_ff + CW'(1);
                  dist_z_ff <= dist_z_ff + DW'(st_ff);
                  plane_ff  <= plane_ff + cxy_ff;
                  state_ff  <= ST_PZ_CHK;
               end else begin
                  dz2_ff    <= mul_p[SQW-1:0];
                  y_ff      <= lo_ff[1];
                  dist_y_ff <= dstart_ff[1];
                  row_ff    <= plane_ff + yofs_ff;
                  state_ff  <= ST_PY_CHK;
               end
            end

            // y rows
            ST_PY_CHK: begin
               if (y_ff >= hi_ff[1]) begin
                  z_ff      <= z_ff + CW'(1);
                  dist_z_ff <= dist_z_ff + DW'(st_ff);
                  plane_ff  <= plane_ff + cxy_ff;
                  state_ff  <= ST_PZ_CHK;
               end else begin
                  mag_ff   <= mag_val;
                  state_ff <= ST_PY_SQ;
               end
            end

            ST_PY_SQ: begin
               if (mag_out) begin
                  y_ff      <= y_ff + CW'(1);
                  dist_y_ff <= dist_y_ff + DW'(st_ff);
                  row_ff    <= row_ff + AW'(cnt_ff[0]);
                  state_ff  <= ST_PY_CHK;
               end else begin
                  sq_ff    <= mul_p[SQW-1:0];
                  state_ff <= ST_PY_SUM;
               end
            end

            ST_PY_SUM: begin
               dyz_ff    <= (SQW+1)'(sq_ff) + (SQW+1)'(dz2_ff);
               x_ff      <= lo_ff[0];
               dist_x_ff <= dstart_ff[0];
               state_ff  <= ST_PX_CHK;
            end

            // x cells
            ST_PX_CHK: begin
               if (x_ff >= hi_ff[0]) begin
                  y_ff      <= y_ff + CW'(1);
                  dist_y_ff <= dist_y_ff + DW'(st_ff);
                  row_ff    <= row_ff + AW'(cnt_ff[0]);
                  state_ff  <= ST_PY_CHK;
               end else begin
                  mag_ff   <= mag_val;
                  state_ff <= ST_PX_SQ;
               end
            end

            ST_PX_SQ: begin
               if (mag_out) begin
                  x_ff      <= x_ff + CW'(1);
                  dist_x_ff <= dist_x_ff + DW'(st_ff);
                  state_ff  <= ST_PX_CHK;
               end else begin
                  sq_ff    <= mul_p[SQW-1:0];
                  state_ff <= ST_PX_TEST;
               end
            end

            ST_PX_TEST: begin
               // the store write happens alongside, a set cell still counts
               if (hit) begin
                  any_ff <= 1'b1;
               end
               x_ff      <= x_ff + CW'(1);
               dist_x_ff <= dist_x_ff + DW'(st_ff);
               state_ff  <= ST_PX_CHK;
            end

            // probe address: cx*(cy*iz + iy) + ix
            ST_PB_M1: begin
               t_ff     <= mul_p[AW-1:0];
               state_ff <= ST_PB_A1;
            end

            ST_PB_A1: begin
               t_ff     <= t_ff + AW'(lo_ff[1]);
               state_ff <= ST_PB_M2;
            end

            ST_PB_M2: begin
               t_ff     <= mul_p[AW-1:0];
               state_ff <= ST_PB_A2;
            end

            ST_PB_A2: begin
               addr_ff  <= t_ff + AW'(lo_ff[0]);
               state_ff <= ST_PB_RD;
            end

            ST_PB_RD: begin
               state_ff <= ST_PB_FIN;
            end

            ST_PB_FIN: begin
               flag_ff  <= occ_rd_ff;
               state_ff <= ST_DONE;
            end

            // invert over the cells in use
            ST_INV_CXY: begin
               cxy_ff   <= mul_p[AW-1:0];
               state_ff <= ST_INV_N;
            end

            ST_INV_N: begin
               n_ff     <= mul_p[AW:0];
               state_ff <= ST_INV_RD;
            end

            ST_INV_RD: begin
               state_ff <= (sweep_ff == n_ff) ? ST_DONE : ST_INV_WR;
            end

            ST_INV_WR: begin
               sweep_ff <= sweep_ff + (AW+1)'(1);
               state_ff <= ST_INV_RD;
            end

            // hand the result to the output register
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.done_operation  <= op_ff;
                  rsp_ff.flag            <= flag_ff;
                  state_ff               <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
